// File: rtl/hmf_pkg.sv
// Shared types, character codes and constant tables of the HTTP message framer.
package hmf_pkg;

    localparam int PREFACE_LEN      = 24;
    localparam int PREFACE_HEAD_LEN = 18;
    localparam int NAME_LEN         = 14;
    localparam int MSG_LEN_W        = 32;

    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef enum logic [1:0] {
        PROTO_NONE = 2'd0,
        PROTO_H1   = 2'd1,
        PROTO_H2   = 2'd2
    } t_protocol;

    typedef struct packed {
        logic step;
        logic restart;
        logic flush;
    } t_h1_ctl;

    typedef struct packed {
        logic                 msg_end;
        logic [MSG_LEN_W-1:0] msg_len;
    } t_h1_stat;

    function automatic logic [7:0] preface_char(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = 8'h50;
            5'd1:    c = 8'h52;
            5'd2:    c = 8'h49;
            5'd3:    c = 8'h20;
            5'd4:    c = 8'h2a;
            5'd5:    c = 8'h20;
            5'd6:    c = 8'h48;
            5'd7:    c = 8'h54;
            5'd8:    c = 8'h54;
            5'd9:    c = 8'h50;
            5'd10:   c = 8'h2f;
            5'd11:   c = 8'h32;
            5'd12:   c = 8'h2e;
            5'd13:   c = 8'h30;
            5'd14:   c = 8'h0d;
            5'd15:   c = 8'h0a;
            5'd16:   c = 8'h0d;
            5'd17:   c = 8'h0a;
            5'd18:   c = 8'h53;
            5'd19:   c = 8'h4d;
            5'd20:   c = 8'h0d;
            5'd21:   c = 8'h0a;
            5'd22:   c = 8'h0d;
            5'd23:   c = 8'h0a;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h63;
            4'd1:    c = 8'h6f;
            4'd2:    c = 8'h6e;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h6e;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h2d;
            4'd8:    c = 8'h6c;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h6e;
            4'd11:   c = 8'h67;
            4'd12:   c = 8'h74;
            4'd13:   c = 8'h68;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/hmf_if.sv
// Valid/ready stream interfaces for the connection bytes and the framing results.
interface hmf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       new_connection;

    modport source (output valid, output byte_value, output new_connection, input ready);
    modport sink (input valid, input byte_value, input new_connection, output ready);
endinterface

interface hmf_out_if;
    logic        valid;
    logic        ready;
    logic        message_end;
    logic [31:0] msg_length;
    logic [1:0]  protocol;

    modport source (output valid, output message_end, output msg_length,
                    output protocol, input ready);
    modport sink (input valid, input message_end, input msg_length,
                  input protocol, output ready);
endinterface

// File: rtl/hmf_h1.sv
// HTTP/1 framing state: header line scan, Content-Length parse and body countdown.
module hmf_h1
    import hmf_pkg::*;
#(
    parameter int LENGTH_WIDTH = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic [7:0] i_byte,
    input  t_h1_ctl  i_ctl,
    output t_h1_stat o_stat
);

    localparam int PW = LENGTH_WIDTH + 4;

    logic [MSG_LEN_W-1:0]    r_count, n_count, c_count;
    logic [1:0]              r_crlf, n_crlf, c_crlf;
    logic                    r_in_body, n_in_body, c_in_body;
    logic [3:0]              r_name_idx, n_name_idx, c_name_idx;
    logic                    r_colon, n_colon, c_colon;
    logic                    r_skip, n_skip, c_skip;
    logic                    r_started, n_started, c_started;
    logic                    r_done, n_done, c_done;
    logic                    r_found, n_found, c_found;
    logic [LENGTH_WIDTH-1:0] r_acc, n_acc, c_acc;
    logic [LENGTH_WIDTH-1:0] r_body, n_body, c_body;

    logic [MSG_LEN_W-1:0]    count_inc;
    logic [LENGTH_WIDTH-1:0] body_dec;
    logic [LENGTH_WIDTH-1:0] cl;
    logic [7:0]              lc;
    logic                    is_digit;
    logic [3:0]              digit;
    logic [PW-1:0]           prod;
    logic                    ovf;
    logic                    msg_end;

    always_comb begin
        c_count    = i_ctl.restart ? '0 : r_count;
        c_crlf     = i_ctl.restart ? '0 : r_crlf;
        c_in_body  = i_ctl.restart ? 1'b0 : r_in_body;
        c_name_idx = i_ctl.restart ? '0 : r_name_idx;
        c_colon    = i_ctl.restart ? 1'b0 : r_colon;
        c_skip     = i_ctl.restart ? 1'b0 : r_skip;
        c_started  = i_ctl.restart ? 1'b0 : r_started;
        c_done     = i_ctl.restart ? 1'b0 : r_done;
        c_found    = i_ctl.restart ? 1'b0 : r_found;
        c_acc      = i_ctl.restart ? '0 : r_acc;
        c_body     = i_ctl.restart ? '0 : r_body;
    end

    assign count_inc = (c_count == '1) ? c_count : c_count + MSG_LEN_W'(1);
    assign body_dec  = c_body - LENGTH_WIDTH'(1);
    assign lc        = (i_byte inside {[CH_UP_A:CH_UP_Z]}) ? i_byte + CASE_OFS : i_byte;
    assign is_digit  = i_byte inside {[CH_ZERO:CH_NINE]};
    assign digit     = 4'(i_byte - CH_ZERO);
    assign prod      = (PW'(c_acc) << 3) + (PW'(c_acc) << 1) + PW'(digit);
    assign ovf       = |prod[PW-1:LENGTH_WIDTH];

    always_comb begin
        n_count    = count_inc;
        n_crlf     = c_crlf;
        n_in_body  = c_in_body;
        n_name_idx = c_name_idx;
        n_colon    = c_colon;
        n_skip     = c_skip;
        n_started  = c_started;
        n_done     = c_done;
        n_found    = c_found;
        n_acc      = c_acc;
        n_body     = c_body;
        msg_end    = 1'b0;
        cl         = '0;

        if (c_in_body) begin
            n_body  = body_dec;
            msg_end = (body_dec == '0);
        end else begin
            if (i_byte == CH_LF) begin
                n_colon    = 1'b0;
                n_skip     = 1'b0;
                n_started  = 1'b0;
                n_done     = 1'b0;
                n_name_idx = '0;
            end else if (!c_skip) begin
                if (!c_colon) begin
                    if (i_byte == CH_COLON) begin
                        if (!c_found && c_name_idx == 4'(NAME_LEN)) begin
                            n_found = 1'b1;
                            n_acc   = '0;
                            n_colon = 1'b1;
                        end else begin
                            n_skip = 1'b1;
                        end
                    end else if (!c_found && c_name_idx < 4'(NAME_LEN) &&
                                 lc == name_char(c_name_idx)) begin
                        n_name_idx = c_name_idx + 4'd1;
                    end else begin
                        n_skip = 1'b1;
                    end
                end else if (!c_done && (c_started || i_byte != CH_SPACE)) begin
                    n_started = 1'b1;
                    if (is_digit) begin
                        if (ovf) begin
                            n_acc  = '0;
                            n_done = 1'b1;
                        end else begin
                            n_acc = prod[LENGTH_WIDTH-1:0];
                        end
                    end else begin
                        n_done = 1'b1;
                    end
                end
            end

            cl = n_found ? n_acc : '0;
            if (i_byte == CH_CR) begin
                n_crlf = (c_crlf == 2'd2) ? 2'd3 : 2'd1;
            end else if (i_byte == CH_LF && c_crlf == 2'd1) begin
                n_crlf = 2'd2;
            end else if (i_byte == CH_LF && c_crlf == 2'd3) begin
                n_crlf = 2'd0;
                if (cl == '0) begin
                    msg_end = 1'b1;
                end else begin
                    n_in_body = 1'b1;
                    n_body    = cl;
                end
            end else begin
                n_crlf = 2'd0;
            end
        end
    end

    assign o_stat.msg_end = msg_end;
    assign o_stat.msg_len = count_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_crlf     <= '0;
            r_in_body  <= 1'b0;
            r_name_idx <= '0;
            r_colon    <= 1'b0;
            r_skip     <= 1'b0;
            r_started  <= 1'b0;
            r_done     <= 1'b0;
            r_found    <= 1'b0;
            r_acc      <= '0;
            r_body     <= '0;
        end else if (i_ctl.step && i_ctl.flush) begin
            r_count    <= '0;
            r_crlf     <= '0;
            r_in_body  <= 1'b0;
            r_name_idx <= '0;
            r_colon    <= 1'b0;
            r_skip     <= 1'b0;
            r_started  <= 1'b0;
            r_done     <= 1'b0;
            r_found    <= 1'b0;
            r_acc      <= '0;
            r_body     <= '0;
        end else if (i_ctl.step) begin
            r_count    <= n_count;
            r_crlf     <= n_crlf;
            r_in_body  <= n_in_body;
            r_name_idx <= n_name_idx;
            r_colon    <= n_colon;
            r_skip     <= n_skip;
            r_started  <= n_started;
            r_done     <= n_done;
            r_found    <= n_found;
            r_acc      <= n_acc;
            r_body     <= n_body;
        end
    end

endmodule

// File: rtl/hmf_mode.sv
// Protocol decision: HTTP/2 preface match, deferred HTTP/1 end and result selection.
module hmf_mode
    import hmf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_byte,
    input  logic                 i_new_conn,
    input  t_h1_stat             i_h1,
    output t_h1_ctl              o_ctl,
    output logic                 o_msg_end,
    output logic [MSG_LEN_W-1:0] o_msg_len,
    output t_protocol            o_protocol
);

    t_protocol  r_mode, n_mode, c_mode;
    logic [4:0] r_pidx, n_pidx, c_pidx;
    logic       r_deferred, n_deferred, c_deferred;
    logic       match;
    logic       step;
    logic       flush;

    assign c_mode     = i_new_conn ? PROTO_NONE : r_mode;
    assign c_pidx     = i_new_conn ? 5'd0 : r_pidx;
    assign c_deferred = i_new_conn ? 1'b0 : r_deferred;
    assign match      = (c_pidx < 5'(PREFACE_LEN)) && (i_byte == preface_char(c_pidx));

    always_comb begin
        n_mode     = c_mode;
        n_pidx     = c_pidx;
        n_deferred = c_deferred;
        step       = 1'b0;
        flush      = 1'b0;
        o_msg_end  = 1'b0;
        o_msg_len  = '0;
        case (c_mode)
            PROTO_H2: begin
                o_msg_end = 1'b1;
                o_msg_len = MSG_LEN_W'(1);
            end
            PROTO_H1: begin
                step      = 1'b1;
                flush     = i_h1.msg_end;
                o_msg_end = i_h1.msg_end;
                o_msg_len = i_h1.msg_end ? i_h1.msg_len : '0;
            end
            PROTO_NONE: begin
                step = 1'b1;
                if (match) begin
                    flush  = i_h1.msg_end;
                    n_pidx = c_pidx + 5'd1;
                    if (i_h1.msg_end) begin
                        n_deferred = 1'b1;
                    end
                    if (n_pidx == 5'(PREFACE_LEN)) begin
                        n_mode     = PROTO_H2;
                        n_deferred = 1'b0;
                        flush      = 1'b1;
                        o_msg_end  = 1'b1;
                        o_msg_len  = MSG_LEN_W'(PREFACE_LEN);
                    end
                end else begin
                    n_mode     = PROTO_H1;
                    n_deferred = 1'b0;
                    flush      = i_h1.msg_end;
                    o_msg_end  = c_deferred || i_h1.msg_end;
                    if (c_deferred) begin
                        o_msg_len = MSG_LEN_W'(PREFACE_HEAD_LEN);
                    end else if (i_h1.msg_end) begin
                        o_msg_len = i_h1.msg_len;
                    end
                end
            end
            default: begin
                n_mode = PROTO_NONE;
            end
        endcase
    end

    assign o_ctl.step    = i_fire && step;
    assign o_ctl.restart = i_new_conn;
    assign o_ctl.flush   = flush;
    assign o_protocol    = n_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= PROTO_NONE;
            r_pidx     <= '0;
            r_deferred <= 1'b0;
        end else if (i_fire) begin
            r_mode     <= n_mode;
            r_pidx     <= n_pidx;
            r_deferred <= n_deferred;
        end
    end

endmodule

// File: rtl/http_message_framer_unit.sv
// Top level of the HTTP message framer: input register, framing logic and result register.
//
// The framer takes one connection byte per word and returns one result word for
// each byte. It accepts a byte in every cycle in which the input register is
// empty or moving on to a free or draining result register, so the sustained
// rate is one byte per cycle. An accepted byte waits in the input register until
// the result register is free or draining; then the protocol
// decision and HTTP/1 framing step write the result register. The HTTP/2
// preface check and the Content-Length parse both run in that single step, with
// the length digits folded in by a shift-and-add.
// Setting new_connection on a byte clears all connection state before that
// byte is framed. LENGTH_WIDTH sets the largest Content-Length value that is
// honored; a larger value frames as an empty body.
module http_message_framer_unit
    import hmf_pkg::*;
#(
    parameter int LENGTH_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hmf_in_if.sink    i_byte_stream,
    hmf_out_if.source o_msg_stream
);

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_new;
    logic                 r_out_valid;
    logic                 r_msg_end;
    logic [MSG_LEN_W-1:0] r_msg_len;
    t_protocol            r_protocol;

    logic                 fire;
    logic                 in_take;
    t_h1_ctl              h1_ctl;
    t_h1_stat             h1_stat;
    logic                 msg_end;
    logic [MSG_LEN_W-1:0] msg_len;
    t_protocol            protocol;

    assign fire    = r_in_valid && (!r_out_valid || o_msg_stream.ready);
    assign i_byte_stream.ready = !r_in_valid || fire;
    assign in_take = i_byte_stream.valid && i_byte_stream.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_byte_stream.byte_value;
            r_in_new  <= i_byte_stream.new_connection;
        end
    end

    hmf_mode u_mode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_byte     (r_in_byte),
        .i_new_conn (r_in_new),
        .i_h1       (h1_stat),
        .o_ctl      (h1_ctl),
        .o_msg_end  (msg_end),
        .o_msg_len  (msg_len),
        .o_protocol (protocol)
    );

    hmf_h1 #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_h1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (r_in_byte),
        .i_ctl   (h1_ctl),
        .o_stat  (h1_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_msg_stream.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_msg_end  <= msg_end;
            r_msg_len  <= msg_len;
            r_protocol <= protocol;
        end
    end

    assign o_msg_stream.valid       = r_out_valid;
    assign o_msg_stream.message_end = r_msg_end;
    assign o_msg_stream.msg_length  = r_msg_len;
    assign o_msg_stream.protocol    = r_protocol;

`ifndef SYNTH
    a_h2_every_word_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_protocol == PROTO_H2) |-> r_msg_end)
        else $error("HTTP/2 result without a message end.");

    a_no_length_without_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_msg_end) |-> (r_msg_len == '0))
        else $error("Nonzero message length on a result without a message end.");

    a_input_word_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("Buffered input word lost while the result side stalled.");
`endif

endmodule

// File: verif/http_message_framer_unit_test.sv
// Self-checking testbench that frames random HTTP/1 and HTTP/2 streams and checks each word.
module http_message_framer_unit_test;
    import hmf_pkg::*;

    localparam int LEN_BITS = 32;
    localparam logic [63:0] LEN_LIMIT = (64'd1 << LEN_BITS) - 64'd1;
    localparam int RANDOM_BYTES = 1300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int CALM_FROM = 600;
    localparam int CALM_TO = 1400;
    localparam int DRAIN_CYCLES = 20;
    localparam int PRINT_LIMIT = 40;

    localparam logic [3:0] F_COLON   = 4'd1;
    localparam logic [3:0] F_SKIP    = 4'd2;
    localparam logic [3:0] F_STARTED = 4'd4;
    localparam logic [3:0] F_DONE    = 4'd8;

    localparam string CRLF = "\015\012";
    localparam string PREFACE_TEXT = "PRI * HTTP/2.0\015\012\015\012SM\015\012\015\012";
    localparam string NAME_TEXT = "content-length";

    typedef struct packed {
        logic [7:0] value;
        logic       fresh;
    } t_conn_byte;

    typedef struct packed {
        logic        msg_end;
        logic [31:0] msg_len;
        t_protocol   proto;
    } t_framing_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hmf_in_if  byte_bus ();
    hmf_out_if result_bus ();

    http_message_framer_unit #(
        .LENGTH_WIDTH(LEN_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_stream(byte_bus),
        .o_msg_stream (result_bus)
    );

    t_conn_byte      pending_bytes[$];
    t_framing_result expected_results[$];
    t_conn_byte      next_byte;
    int              queued_bytes = 0;
    bit              fresh_next = 1'b0;
    bit              byte_taken = 1'b0;
    int              cycle_count = 0;
    int              fail_count = 0;

    t_protocol   proto_mode;
    int          preface_idx;
    bit          deferred_end;
    logic [31:0] byte_count;
    logic [1:0]  crlf_state;
    bit          in_body;
    logic [63:0] body_left;
    int          name_idx;
    logic [3:0]  line_flags;
    bit          length_found;
    logic [63:0] length_acc;

    always #6 i_clk = ~i_clk;

    function automatic void clear_message();
        byte_count = '0;
        crlf_state = '0;
        in_body = 1'b0;
        name_idx = 0;
        line_flags = '0;
        length_found = 1'b0;
        length_acc = '0;
        body_left = '0;
    endfunction

    function automatic void restart_connection();
        proto_mode = PROTO_NONE;
        preface_idx = 0;
        deferred_end = 1'b0;
        clear_message();
    endfunction

    function automatic void scan_header(input logic [7:0] b);
        logic [7:0]  lc;
        logic [63:0] digit;
        if (b == CH_LF) begin
            line_flags = '0;
            name_idx = 0;
            return;
        end
        if ((line_flags & F_SKIP) != 0) return;
        if ((line_flags & F_COLON) == 0) begin
            if (b == CH_COLON) begin
                if (!length_found && name_idx == NAME_LEN) begin
                    length_found = 1'b1;
                    length_acc = '0;
                    line_flags |= F_COLON;
                end else begin
                    line_flags |= F_SKIP;
                end
            end else begin
                lc = (b >= CH_UP_A && b <= CH_UP_Z) ? b + CASE_OFS : b;
                if (!length_found && name_idx < NAME_LEN && lc == NAME_TEXT[name_idx])
                    name_idx++;
                else
                    line_flags |= F_SKIP;
            end
            return;
        end
        if ((line_flags & F_DONE) != 0) return;
        if ((line_flags & F_STARTED) == 0) begin
            if (b == CH_SPACE) return;
            line_flags |= F_STARTED;
        end
        if (b >= CH_ZERO && b <= CH_NINE) begin
            digit = 64'(b - CH_ZERO);
            if (length_acc > (LEN_LIMIT - digit) / 64'd10) begin
                length_acc = '0;
                line_flags |= F_DONE;
            end else begin
                length_acc = length_acc * 64'd10 + digit;
            end
        end else begin
            line_flags |= F_DONE;
        end
    endfunction

    function automatic bit frame_h1(input logic [7:0] b, output logic [31:0] len);
        logic [63:0] body_len;
        len = '0;
        if (byte_count != 32'hFFFF_FFFF) byte_count++;
        if (in_body) begin
            body_left--;
            if (body_left == 0) begin
                len = byte_count;
                return 1'b1;
            end
            return 1'b0;
        end
        scan_header(b);
        if (b == CH_CR) begin
            crlf_state = (crlf_state == 2'd2) ? 2'd3 : 2'd1;
        end else if (b == CH_LF && crlf_state == 2'd1) begin
            crlf_state = 2'd2;
        end else if (b == CH_LF && crlf_state == 2'd3) begin
            body_len = length_found ? length_acc : 64'd0;
            crlf_state = '0;
            if (body_len == 0) begin
                len = byte_count;
                return 1'b1;
            end
            in_body = 1'b1;
            body_left = body_len;
        end else begin
            crlf_state = '0;
        end
        return 1'b0;
    endfunction

    function automatic t_framing_result frame_byte(input logic [7:0] b, input logic fresh);
        t_framing_result r;
        logic [31:0]     len;
        bit              ended;
        bit              had_deferred;
        len = '0;
        ended = 1'b0;
        if (fresh) restart_connection();
        if (proto_mode == PROTO_H2) begin
            ended = 1'b1;
            len = 32'd1;
        end else if (proto_mode == PROTO_H1) begin
            ended = frame_h1(b, len);
            if (ended) clear_message();
        end else if (preface_idx < PREFACE_LEN && b == PREFACE_TEXT[preface_idx]) begin
            if (frame_h1(b, len)) begin
                deferred_end = 1'b1;
                clear_message();
            end
            preface_idx++;
            if (preface_idx >= PREFACE_LEN) begin
                proto_mode = PROTO_H2;
                deferred_end = 1'b0;
                clear_message();
                ended = 1'b1;
                len = PREFACE_LEN;
            end
        end else begin
            had_deferred = deferred_end;
            proto_mode = PROTO_H1;
            deferred_end = 1'b0;
            ended = frame_h1(b, len);
            if (ended) clear_message();
            if (had_deferred) begin
                ended = 1'b1;
                len = PREFACE_HEAD_LEN;
            end
        end
        r.msg_end = ended;
        r.msg_len = ended ? len : '0;
        r.proto = proto_mode;
        return r;
    endfunction

    function automatic void add_byte(input logic [7:0] v);
        t_conn_byte c;
        c.value = v;
        c.fresh = fresh_next;
        fresh_next = 1'b0;
        pending_bytes.insert(pending_bytes.size(), c);
        queued_bytes++;
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    function automatic string mixed_case(input string s);
        string t;
        t = s;
        for (int i = 0; i < t.len(); i++) begin
            if (t[i] >= "a" && t[i] <= "z" && $urandom_range(1) == 1) t[i] = t[i] - CASE_OFS;
        end
        return t;
    endfunction

    // Returns 0 when the message was left inside a body that will not complete.
    function automatic bit add_h1_message();
        int    hdrs;
        int    at;
        int    pick;
        int    body_len;
        bit    with_len;
        bit    open_body;
        string val;
        body_len = 0;
        open_body = 1'b0;
        pick = $urandom_range(2);
        if (pick == 0) begin
            add_text("GET / HTTP/1.1");
        end else if (pick == 1) begin
            add_text("POST /form HTTP/1.0");
        end else begin
            repeat ($urandom_range(8)) add_byte(8'($urandom_range(8'h21, 8'h7e)));
        end
        add_text(CRLF);
        hdrs = $urandom_range(3);
        at = $urandom_range(hdrs);
        with_len = $urandom_range(99) < 75;
        for (int i = 0; i <= hdrs; i++) begin
            if (with_len && i == at) begin
                add_text(mixed_case(NAME_TEXT));
                add_text(":");
                repeat ($urandom_range(3)) add_byte(CH_SPACE);
                pick = $urandom_range(99);
                if (pick < 70) begin
                    body_len = $urandom_range(24);
                    val = $sformatf("%0d", body_len);
                end else if (pick < 78) begin
                    val = $sformatf("%0d", 64'd4294967296 + 64'($urandom()));
                end else if (pick < 86) begin
                    val = ($urandom_range(1) == 1) ? "none" : "";
                end else if (pick < 94) begin
                    body_len = $urandom_range(9);
                    val = $sformatf("00%0d", body_len);
                end else begin
                    open_body = 1'b1;
                    val = $sformatf("%0d", $urandom_range(32'hFFFF_FFFF, 32'd100000));
                end
                add_text(val);
                if ($urandom_range(99) < 30) add_text(";x");
                add_text(CRLF);
                if ($urandom_range(99) < 25) add_text({"Content-Length: 9999", CRLF});
            end
            if (i < hdrs) begin
                pick = $urandom_range(4);
                if (pick == 0) add_text({"host: h", CRLF});
                else if (pick == 1) add_text({"Content-Type: text", CRLF});
                else if (pick == 2) add_text({"content-lengthy: 5", CRLF});
                else if (pick == 3) add_text({"Content-Lengt: 7", CRLF});
                else add_text({"X-Len:9", CRLF});
            end
        end
        add_text(CRLF);
        if (open_body) begin
            repeat ($urandom_range(20)) add_byte(8'($urandom_range(255)));
            return 1'b0;
        end
        repeat (body_len) add_byte(8'($urandom_range(255)));
        return 1'b1;
    endfunction

    function automatic bit pause_now();
        return (cycle_count < CALM_FROM || cycle_count >= CALM_TO) && $urandom_range(99) < 35;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s got %0h expected %0h",
                     cycle_count, what, got, want);
        fail_count++;
    endtask

    task automatic check_result();
        t_framing_result want;
        if (expected_results.size() == 0) begin
            report_mismatch("result word with no byte pending", result_bus.msg_length, '0);
        end else begin
            want = expected_results.pop_front();
            if (result_bus.message_end !== want.msg_end)
                report_mismatch("message_end", 32'(result_bus.message_end), 32'(want.msg_end));
            if (result_bus.msg_length !== want.msg_len)
                report_mismatch("msg_length", result_bus.msg_length, want.msg_len);
            if (result_bus.protocol !== want.proto)
                report_mismatch("protocol", 32'(result_bus.protocol), 32'(want.proto));
        end
    endtask

    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            cycle_count++;
            byte_taken = byte_bus.valid && byte_bus.ready;
            if (i_rst_n && byte_taken)
                expected_results.insert(expected_results.size(),
                                        frame_byte(byte_bus.byte_value,
                                                   byte_bus.new_connection));
            if (i_rst_n && result_bus.valid && result_bus.ready) check_result();
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            byte_bus.valid <= 1'b0;
            result_bus.ready <= 1'b0;
        end else begin
            result_bus.ready <= !pause_now();
            if (!byte_bus.valid || byte_taken) begin
                if (pending_bytes.size() != 0 && !pause_now()) begin
                    next_byte = pending_bytes.pop_front();
                    byte_bus.valid <= 1'b1;
                    byte_bus.byte_value <= next_byte.value;
                    byte_bus.new_connection <= next_byte.fresh;
                end else begin
                    byte_bus.valid <= 1'b0;
                end
            end
        end
    end

    initial begin
        int         kind;
        int         k;
        int         directed_end;
        logic [7:0] v;
        i_rst_n = 1'b0;
        byte_bus.valid = 1'b0;
        byte_bus.byte_value = '0;
        byte_bus.new_connection = 1'b0;
        result_bus.ready = 1'b0;
        restart_connection();

        // Full preface, then two bytes passed through in HTTP/2 mode.
        fresh_next = 1'b1;
        add_text(PREFACE_TEXT);
        add_byte(8'h00);
        add_byte(8'hff);
        // Length header on the very first line, spaces before the digits, CR and LF in the body.
        fresh_next = 1'b1;
        add_text({"Content-Length:   3", CRLF, CRLF, "a", CRLF});
        // A value wider than the length field frames as an empty body.
        fresh_next = 1'b1;
        add_text({"GET / HTTP/1.1", CRLF, "CONTENT-length: 99999999999", CRLF, CRLF});
        // The largest value that fits; the connection is dropped inside the body.
        fresh_next = 1'b1;
        add_text({"POST / HTTP/1.1", CRLF, "content-length: 4294967295", CRLF, CRLF, "z"});
        // The preface head ends a shadow message that is reported on the mismatch.
        fresh_next = 1'b1;
        add_text({PREFACE_TEXT.substr(0, PREFACE_HEAD_LEN - 1), "X", CRLF, CRLF});
        // An early mismatch in the preface.
        fresh_next = 1'b1;
        add_text({"PRX", CRLF, CRLF});
        directed_end = queued_bytes;

        while (queued_bytes < directed_end + RANDOM_BYTES) begin
            kind = $urandom_range(99);
            fresh_next = 1'b1;
            if (kind < 45) begin
                for (int i = $urandom_range(1, 4); i > 0; i--) begin
                    if (!add_h1_message()) break;
                end
                if ($urandom_range(99) < 15)
                    repeat ($urandom_range(1, 10)) add_byte(8'($urandom_range(255)));
            end else if (kind < 60) begin
                add_text(PREFACE_TEXT);
                repeat ($urandom_range(15)) add_byte(8'($urandom_range(255)));
            end else if (kind < 88) begin
                k = (kind < 75) ? $urandom_range(1, PREFACE_LEN - 1)
                                : $urandom_range(PREFACE_HEAD_LEN, PREFACE_LEN - 1);
                for (int i = 0; i < k; i++) add_byte(PREFACE_TEXT[i]);
                do v = 8'($urandom_range(255)); while (v == PREFACE_TEXT[k]);
                add_byte(v);
                void'(add_h1_message());
            end else begin
                repeat ($urandom_range(5, 40)) begin
                    if ($urandom_range(99) < 5) fresh_next = 1'b1;
                    add_byte(8'($urandom_range(255)));
                end
            end
        end

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || byte_bus.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
rtl/hmf_pkg.sv
rtl/hmf_if.sv
rtl/hmf_h1.sv
rtl/hmf_mode.sv
rtl/http_message_framer_unit.sv
verif/http_message_framer_unit_test.sv
